// ----- rtl/dats_pkg.sv -----
// ----------------------------------------------------------------------------
// DNS answer type scanner package
// Shared types and constants for the byte-serial DNS response parser.
// ----------------------------------------------------------------------------
package dats_pkg;

  // Limits of the message format
  localparam int unsigned MAX_NAME_BYTES      = 255;
  localparam int unsigned MAX_PACKET_BYTES    = 65535;
  localparam int unsigned HEADER_BYTES        = 12;
  localparam int unsigned FIXED_RR_BYTES      = 10;
  localparam int unsigned QUESTION_TAIL_BYTES = 4;

  // Header byte positions of the question and answer counts (big-endian)
  localparam logic [15:0] QDCOUNT_HI_POS = 16'd4;
  localparam logic [15:0] QDCOUNT_LO_POS = 16'd5;
  localparam logic [15:0] ANCOUNT_HI_POS = 16'd6;
  localparam logic [15:0] ANCOUNT_LO_POS = 16'd7;

  // Byte indexes inside the fixed part of an answer record
  localparam logic [3:0] RR_TYPE_HI_IDX  = 4'd0;
  localparam logic [3:0] RR_TYPE_LO_IDX  = 4'd1;
  localparam logic [3:0] RR_RDLEN_HI_IDX = 4'd8;
  localparam logic [3:0] RR_RDLEN_LO_IDX = 4'd9;

  // Top two bits of a name length byte
  localparam logic [1:0] LABEL_KIND_PLAIN = 2'b00;
  localparam logic [1:0] LABEL_KIND_PTR   = 2'b11;

  // Outcome flags of one packet
  localparam logic [1:0] FLAG_NONE  = 2'b00;
  localparam logic [1:0] FLAG_FOUND = 2'b01;
  localparam logic [1:0] FLAG_BAD   = 2'b10;

  // Reset value of the wanted record type (A record)
  localparam logic [15:0] WANTED_TYPE_RESET = 16'd1;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QNAME  = 4'd1,
    PH_QPTR   = 4'd2,
    PH_QTAIL  = 4'd3,
    PH_ANAME  = 4'd4,
    PH_APTR   = 4'd5,
    PH_AFIX   = 4'd6,
    PH_ADATA  = 4'd7,
    PH_DONE   = 4'd8
  } phase_t;

  // One input item as held in the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // One result item
  typedef struct packed {
    logic        found;
    logic        malformed;
    logic [15:0] match_offset;
  } result_t;

endpackage

// ----- rtl/dats_in_stage.sv -----
// ----------------------------------------------------------------------------
// DNS answer type scanner input register
// Holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module dats_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dats_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output dats_pkg::item_t item
);

  logic            vld_r;
  logic            vld_nxt;
  dats_pkg::item_t item_r;

  // A new item may enter when the register is empty or drains this cycle.
  assign in_ready = !vld_r || take;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (take) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

// ----- rtl/dats_parser.sv -----
// ----------------------------------------------------------------------------
// DNS answer type scanner parser
// Field counters and phase register, updated once per consumed byte.
// ----------------------------------------------------------------------------
module dats_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  dats_pkg::item_t   item,
  input  logic [15:0]       wanted_type,
  output dats_pkg::result_t result
);

  dats_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [3:0]  field_cnt_r, field_cnt_nxt;
  logic [15:0] questions_left_r, questions_left_nxt;
  logic [15:0] answers_left_r, answers_left_nxt;
  logic [5:0]  label_left_r, label_left_nxt;
  logic [7:0]  name_len_r, name_len_nxt;
  logic [15:0] record_type_r, record_type_nxt;
  logic [15:0] data_left_r, data_left_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [15:0] match_offset_r, match_offset_nxt;

  // Next-state logic for one byte
  always_comb begin
    logic [7:0]       b;
    logic [15:0]      pos;
    logic             in_name;
    logic             rec_end;
    dats_pkg::phase_t ptr_ph;
    dats_pkg::phase_t next_ph;
    logic [8:0]       total;
    logic [3:0]       fcnt_inc;
    logic [15:0]      qleft_dec;
    logic [15:0]      aleft_dec;
    logic [1:0]       res_flags;

    b        = item.data;
    pos      = byte_offset_r;
    in_name  = 1'b0;
    rec_end  = 1'b0;
    ptr_ph   = dats_pkg::PH_QPTR;
    next_ph  = dats_pkg::PH_QTAIL;
    total    = {1'b0, name_len_r} + 9'd1 + {1'b0, b};
    fcnt_inc = field_cnt_r + 4'd1;
    qleft_dec = questions_left_r - 16'd1;
    aleft_dec = answers_left_r - 16'd1;

    phase_nxt          = phase_r;
    byte_offset_nxt    = byte_offset_r;
    field_cnt_nxt      = field_cnt_r;
    questions_left_nxt = questions_left_r;
    answers_left_nxt   = answers_left_r;
    label_left_nxt     = label_left_r;
    name_len_nxt       = name_len_r;
    record_type_nxt    = record_type_r;
    data_left_nxt      = data_left_r;
    flags_nxt          = flags_r;
    match_offset_nxt   = match_offset_r;

    if (phase_r != dats_pkg::PH_DONE) begin
      if (pos >= 16'(dats_pkg::MAX_PACKET_BYTES)) begin
        flags_nxt = dats_pkg::FLAG_BAD;
        phase_nxt = dats_pkg::PH_DONE;
      end else begin
        unique case (phase_r)
          dats_pkg::PH_HEADER: begin
            if (pos == dats_pkg::QDCOUNT_HI_POS) begin
              questions_left_nxt = {b, 8'd0};
            end else if (pos == dats_pkg::QDCOUNT_LO_POS) begin
              questions_left_nxt = {questions_left_r[15:8], b};
            end else if (pos == dats_pkg::ANCOUNT_HI_POS) begin
              answers_left_nxt = {b, 8'd0};
            end else if (pos == dats_pkg::ANCOUNT_LO_POS) begin
              answers_left_nxt = {answers_left_r[15:8], b};
            end
            if (pos == 16'(dats_pkg::HEADER_BYTES - 1)) begin
              if (questions_left_r == 16'd0 || answers_left_r == 16'd0) begin
                flags_nxt = dats_pkg::FLAG_NONE;
                phase_nxt = dats_pkg::PH_DONE;
              end else begin
                name_len_nxt   = 8'd0;
                label_left_nxt = 6'd0;
                field_cnt_nxt  = 4'd0;
                phase_nxt      = dats_pkg::PH_QNAME;
              end
            end
          end
          dats_pkg::PH_QNAME: begin
            in_name = 1'b1;
            ptr_ph  = dats_pkg::PH_QPTR;
            next_ph = dats_pkg::PH_QTAIL;
          end
          dats_pkg::PH_ANAME: begin
            in_name = 1'b1;
            ptr_ph  = dats_pkg::PH_APTR;
            next_ph = dats_pkg::PH_AFIX;
          end
          dats_pkg::PH_QPTR, dats_pkg::PH_APTR: begin
            // Second byte of a compression pointer closes the name.
            name_len_nxt   = 8'd0;
            label_left_nxt = 6'd0;
            field_cnt_nxt  = 4'd0;
            phase_nxt      = (phase_r == dats_pkg::PH_QPTR) ? dats_pkg::PH_QTAIL
                                                            : dats_pkg::PH_AFIX;
          end
          dats_pkg::PH_QTAIL: begin
            field_cnt_nxt = fcnt_inc;
            if (fcnt_inc >= 4'(dats_pkg::QUESTION_TAIL_BYTES)) begin
              questions_left_nxt = qleft_dec;
              name_len_nxt       = 8'd0;
              label_left_nxt     = 6'd0;
              field_cnt_nxt      = 4'd0;
              phase_nxt          = (qleft_dec != 16'd0) ? dats_pkg::PH_QNAME
                                                        : dats_pkg::PH_ANAME;
            end
          end
          dats_pkg::PH_AFIX: begin
            if (field_cnt_r == dats_pkg::RR_TYPE_HI_IDX) begin
              record_type_nxt = {b, 8'd0};
            end else if (field_cnt_r == dats_pkg::RR_TYPE_LO_IDX) begin
              record_type_nxt = {record_type_r[15:8], b};
            end else if (field_cnt_r == dats_pkg::RR_RDLEN_HI_IDX) begin
              data_left_nxt = {b, 8'd0};
            end else if (field_cnt_r == dats_pkg::RR_RDLEN_LO_IDX) begin
              data_left_nxt = {data_left_r[15:8], b};
            end
            field_cnt_nxt = fcnt_inc;
            if (fcnt_inc >= 4'(dats_pkg::FIXED_RR_BYTES)) begin
              field_cnt_nxt    = 4'd0;
              match_offset_nxt = pos + 16'd1;
              if (data_left_nxt == 16'd0) begin
                rec_end = 1'b1;
              end else begin
                phase_nxt = dats_pkg::PH_ADATA;
              end
            end
          end
          dats_pkg::PH_ADATA: begin
            data_left_nxt = data_left_r - 16'd1;
            if (data_left_nxt == 16'd0) begin
              rec_end = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end

    // Name bytes: label skipping, pointers, label kinds and length limit
    if (in_name) begin
      if (label_left_r != 6'd0) begin
        label_left_nxt = label_left_r - 6'd1;
      end else if (b[7:6] == dats_pkg::LABEL_KIND_PTR) begin
        phase_nxt = ptr_ph;
      end else if (b[7:6] != dats_pkg::LABEL_KIND_PLAIN) begin
        flags_nxt = dats_pkg::FLAG_BAD;
        phase_nxt = dats_pkg::PH_DONE;
      end else if (b == 8'd0) begin
        if ({1'b0, name_len_r} + 9'd1 > 9'(dats_pkg::MAX_NAME_BYTES)) begin
          flags_nxt = dats_pkg::FLAG_BAD;
          phase_nxt = dats_pkg::PH_DONE;
        end else begin
          name_len_nxt   = 8'd0;
          label_left_nxt = 6'd0;
          field_cnt_nxt  = 4'd0;
          phase_nxt      = next_ph;
        end
      end else if (total > 9'(dats_pkg::MAX_NAME_BYTES)) begin
        flags_nxt = dats_pkg::FLAG_BAD;
        phase_nxt = dats_pkg::PH_DONE;
      end else begin
        name_len_nxt   = total[7:0];
        label_left_nxt = b[5:0];
      end
    end

    // End of an answer record: match, last answer, or next answer name
    if (rec_end) begin
      if (record_type_nxt == wanted_type) begin
        flags_nxt = dats_pkg::FLAG_FOUND;
        phase_nxt = dats_pkg::PH_DONE;
      end else begin
        answers_left_nxt = aleft_dec;
        if (aleft_dec == 16'd0) begin
          flags_nxt = dats_pkg::FLAG_NONE;
          phase_nxt = dats_pkg::PH_DONE;
        end else begin
          name_len_nxt   = 8'd0;
          label_left_nxt = 6'd0;
          field_cnt_nxt  = 4'd0;
          phase_nxt      = dats_pkg::PH_ANAME;
        end
      end
    end

    // Byte offset saturates at the packet limit.
    if (byte_offset_r < 16'(dats_pkg::MAX_PACKET_BYTES)) begin
      byte_offset_nxt = byte_offset_r + 16'd1;
    end

    // A packet that ends with parsing still open is malformed.
    res_flags           = (phase_nxt != dats_pkg::PH_DONE) ? dats_pkg::FLAG_BAD : flags_nxt;
    result.found        = res_flags[0];
    result.malformed    = res_flags[1];
    result.match_offset = res_flags[0] ? match_offset_nxt : 16'd0;

    // The final byte returns all packet state to its start values.
    if (item.last) begin
      phase_nxt          = dats_pkg::PH_HEADER;
      byte_offset_nxt    = 16'd0;
      field_cnt_nxt      = 4'd0;
      questions_left_nxt = 16'd0;
      answers_left_nxt   = 16'd0;
      label_left_nxt     = 6'd0;
      name_len_nxt       = 8'd0;
      record_type_nxt    = 16'd0;
      data_left_nxt      = 16'd0;
      flags_nxt          = dats_pkg::FLAG_NONE;
      match_offset_nxt   = 16'd0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= dats_pkg::PH_HEADER;
      byte_offset_r    <= 16'd0;
      field_cnt_r      <= 4'd0;
      questions_left_r <= 16'd0;
      answers_left_r   <= 16'd0;
      label_left_r     <= 6'd0;
      name_len_r       <= 8'd0;
      record_type_r    <= 16'd0;
      data_left_r      <= 16'd0;
      flags_r          <= dats_pkg::FLAG_NONE;
      match_offset_r   <= 16'd0;
    end else if (take) begin
      phase_r          <= phase_nxt;
      byte_offset_r    <= byte_offset_nxt;
      field_cnt_r      <= field_cnt_nxt;
      questions_left_r <= questions_left_nxt;
      answers_left_r   <= answers_left_nxt;
      label_left_r     <= label_left_nxt;
      name_len_r       <= name_len_nxt;
      record_type_r    <= record_type_nxt;
      data_left_r      <= data_left_nxt;
      flags_r          <= flags_nxt;
      match_offset_r   <= match_offset_nxt;
    end
  end

endmodule

// ----- rtl/dats_out_stage.sv -----
// ----------------------------------------------------------------------------
// DNS answer type scanner result register
// Holds one packet result until the receiver takes it.
// ----------------------------------------------------------------------------
module dats_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  dats_pkg::result_t result,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output dats_pkg::result_t out_result
);

  logic              vld_r;
  logic              vld_nxt;
  dats_pkg::result_t result_r;

  // The register can take a result when empty or emptied this cycle.
  assign free = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = vld_r;
  assign out_result = result_r;

endmodule

// ----- rtl/dns_answer_type_scanner.sv -----
// ----------------------------------------------------------------------------
// DNS answer type scanner
// Scans a DNS response byte by byte and reports an answer of a wanted type.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one message byte per item, with in_last_byte set
//   on the final byte. One result item per packet appears on the out_
//   channel: out_found, out_malformed and out_match_offset (the data offset
//   of the matching answer, 0 when nothing was found).
//   The cfg_ channel writes the wanted record type; it is always ready and
//   should be written only while no packet is in flight.
//   Throughput is one byte per cycle while no last byte waits for the
//   result register: an input register feeds the parser, whose field
//   counters update once per consumed byte, and a result register decouples
//   the receiver. A packet's result is loaded into the result register when
//   its last byte leaves the input register and the result register is free.
//   Reset clears all parse state, empties both registers and sets the wanted
//   type to 1 (A record).
//   While the receiver stalls, bytes that are not the last of a packet keep
//   flowing; a last byte waits in the input register until the result
//   register is free, and in_ready stays low while it waits.
// ----------------------------------------------------------------------------
module dns_answer_type_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic        out_malformed,
  output logic [15:0] out_match_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_wanted_type
);

  dats_pkg::item_t   in_item;
  dats_pkg::item_t   item;
  dats_pkg::result_t result;
  dats_pkg::result_t out_result;
  logic              item_valid;
  logic              take;
  logic              load;
  logic              out_free;
  logic [15:0]       wanted_type_r;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_type_r <= dats_pkg::WANTED_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      wanted_type_r <= cfg_wanted_type;
    end
  end

  // A byte is consumed unless it ends a packet and the result is blocked.
  assign take = item_valid && (!item.last || out_free);
  assign load = take && item.last;

  assign in_item.data = in_packet_byte;
  assign in_item.last = in_last_byte;

  dats_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dats_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .item        (item),
    .wanted_type (wanted_type_r),
    .result      (result)
  );

  dats_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign out_found        = out_result.found;
  assign out_malformed    = out_result.malformed;
  assign out_match_offset = out_result.match_offset;

  // A result item is never both found and malformed.
  a_found_xor_bad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_malformed))
    else $error("result both found and malformed");

  // The match offset is zero whenever nothing was found.
  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_offset == 16'd0))
    else $error("nonzero match offset without a match");

  // A final byte is consumed only when the result register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> out_free)
    else $error("result register overwritten");

  // A newly loaded result shows up as valid in the next cycle.
  a_load_visible: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("loaded result not visible");

endmodule
